// File: rtl/core/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types and codes for the hub port enumerator.
// ----------------------------------------------------------------------------
package hpe_pkg;

  localparam int MAX_PORTS_DEF = 7;

  // input action codes
  localparam logic [2:0] ACT_START_PWR = 3'd0;
  localparam logic [2:0] ACT_PWR_DONE  = 3'd1;
  localparam logic [2:0] ACT_STAT_DONE = 3'd2;
  localparam logic [2:0] ACT_OTHER     = 3'd3;
  localparam logic [2:0] ACT_CHANGE    = 3'd4;
  localparam logic [2:0] ACT_DB_TICK   = 3'd5;
  localparam logic [2:0] ACT_RST_TICK  = 3'd6;

  // request kinds
  localparam logic [2:0] K_POWER     = 3'd0;
  localparam logic [2:0] K_CLR_CONN  = 3'd1;
  localparam logic [2:0] K_CLR_RESET = 3'd5;
  localparam logic [2:0] K_GETSTAT   = 3'd6;
  localparam logic [2:0] K_SETRESET  = 3'd7;

  // port phases
  localparam logic [3:0] PH_OFF    = 4'd0;
  localparam logic [3:0] PH_DISC   = 4'd1;
  localparam logic [3:0] PH_DB1    = 4'd2;
  localparam logic [3:0] PH_DB5    = 4'd6;
  localparam logic [3:0] PH_RESET  = 4'd7;
  localparam logic [3:0] PH_RECOV  = 4'd8;
  localparam logic [3:0] PH_ACTIVE = 4'd9;

  // wPortStatus bit positions
  localparam int ST_CONNECT = 0;
  localparam int ST_ENABLE  = 1;
  localparam int ST_LOW     = 9;
  localparam int ST_HIGH    = 10;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  port;
    logic [15:0] status;
    logic [7:0]  change_bits;
    logic        enum_busy;
  } item_t;

  typedef struct packed {
    logic       req_valid;
    logic [2:0] req_kind;
    logic [2:0] req_port;
    logic       start_debounce;
    logic       start_reset_timer;
    logic       attach_device;
    logic [1:0] attach_speed;
    logic       detach_device;
    logic [2:0] event_port;
    logic       open_status_pipe;
  } result_t;

  // shared control state, everything but the per-port phases
  typedef struct packed {
    logic [7:0][7:0] pending;
    logic            in_flight;
    logic [7:0]      db_ports;
    logic [2:0]      rst_port;
    logic [1:0]      rst_speed;
    logic            rst_busy;
    logic            pipe_open;
  } ctrl_t;

endpackage

// File: rtl/core/usb_hub_port_enumerator_unit.sv
// ----------------------------------------------------------------------------
// usb_hub_port_enumerator_unit
// Per-port connect debounce, reset and attach sequencing for a hub.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  in_     | slave     | tdata: port, status, change_bits, enum_busy; tuser: action
//  out_    | master    | tdata: all result fields
//  cfg_    | write     | num_ports
//
// One item per cycle while the result is not stalled; each item passes the input register, then the result register.
// All state is updated in the single step between the two registers.
// A stalled result holds both stages; the input register still fills once.
// Synchronous active-low reset puts every port off and clears all masks.
// ----------------------------------------------------------------------------
module usb_hub_port_enumerator_unit #(
  parameter int MAX_PORTS = hpe_pkg::MAX_PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] port, [18:3] status, [26:19] change_bits, [27] enum_busy
  input  logic [31:0] in_tdata,
  // [2:0] action
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] req_valid, [3:1] req_kind, [6:4] req_port, [7] start_debounce,
  // [8] start_reset_timer, [9] attach_device, [11:10] attach_speed,
  // [12] detach_device, [15:13] event_port, [16] open_status_pipe
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  logic             in_valid_r;
  hpe_pkg::item_t   item_r;
  logic             out_valid_r;
  hpe_pkg::result_t res_r;
  hpe_pkg::result_t res_nxt;
  hpe_pkg::ctrl_t   ctrl_r;
  hpe_pkg::ctrl_t   ctrl_nxt;
  logic [3:0]       phase_r   [MAX_PORTS];
  logic [3:0]       phase_nxt [MAX_PORTS];
  logic [2:0]       num_ports_r;
  logic             advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.open_status_pipe, res_r.event_port,
                       res_r.detach_device, res_r.attach_speed, res_r.attach_device,
                       res_r.start_reset_timer, res_r.start_debounce, res_r.req_port,
                       res_r.req_kind, res_r.req_valid};

  hpe_step #(.MAX_PORTS(MAX_PORTS)) u_step (
    .item      (item_r),
    .num_ports (num_ports_r),
    .ctrl      (ctrl_r),
    .phase     (phase_r),
    .ctrl_nxt  (ctrl_nxt),
    .phase_nxt (phase_nxt),
    .res       (res_nxt)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ports_r <= '0;
    end else if (cfg_wr_en) begin
      num_ports_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= '{action: in_tuser, port: in_tdata[2:0], status: in_tdata[18:3],
                  change_bits: in_tdata[26:19], enum_busy: in_tdata[27]};
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ctrl_r      <= '0;
      for (int i = 0; i < MAX_PORTS; i++) phase_r[i] <= hpe_pkg::PH_OFF;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        ctrl_r  <= ctrl_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // checks
  a_idle_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.req_valid |-> res_r.req_kind == 3'd0 && res_r.req_port == 3'd0)
    else $error("request fields set without a request");

  a_req_port_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.req_valid && res_r.req_kind != hpe_pkg::K_GETSTAT
      |-> res_r.req_port != 3'd0)
    else $error("request to port zero");

  a_attach_detach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.attach_device && res_r.detach_device) &&
                    res_r.attach_speed != 2'd3)
    else $error("bad attach/detach event");

  a_req_sets_flight: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && res_nxt.req_valid |=> ctrl_r.in_flight)
    else $error("issued request not marked in flight");

endmodule

// File: rtl/core/hpe_step.sv
// ----------------------------------------------------------------------------
// hpe_step
// Next-state and result logic for one item: phase update, request issue
// and pending-mask arbitration.
// ----------------------------------------------------------------------------
module hpe_step #(
  parameter int MAX_PORTS = hpe_pkg::MAX_PORTS_DEF
) (
  input  hpe_pkg::item_t   item,
  input  logic [2:0]       num_ports,
  input  hpe_pkg::ctrl_t   ctrl,
  input  logic [3:0]       phase     [MAX_PORTS],
  output hpe_pkg::ctrl_t   ctrl_nxt,
  output logic [3:0]       phase_nxt [MAX_PORTS],
  output hpe_pkg::result_t res
);

  logic [2:0] n;
  logic [7:0] base_mask;

  assign n = (32'(num_ports) < MAX_PORTS) ? num_ports : 3'(MAX_PORTS);
  assign base_mask = 8'((9'd2 << n) - 9'd1);

  function automatic logic [7:0] vmask(input logic [2:0] k, input logic [7:0] m);
    return (k == hpe_pkg::K_GETSTAT) ? m : (m & 8'hFE);
  endfunction

  function automatic logic [7:0] lowbit(input logic [7:0] x);
    return x & (~x + 8'd1);
  endfunction

  function automatic logic [2:0] enc(input logic [7:0] x);
    logic [2:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      if (x[b]) r = 3'(b);
    end
    return r;
  endfunction

  always_comb begin
    hpe_pkg::ctrl_t   c;
    hpe_pkg::result_t r;
    logic [3:0] ph;
    logic [3:0] ph_new;
    logic [3:0] rph;
    logic       port_ok;
    logic       rp_ok;
    logic       conn;
    logic [7:0] bit8;
    logic [7:0] smask;
    logic [2:0] skind;
    logic [7:0] lb;
    logic       found;

    c     = ctrl;
    r     = '0;
    ph    = '0;
    rph   = '0;
    smask = '0;
    skind = '0;
    found = 1'b0;
    lb    = '0;
    conn  = item.status[hpe_pkg::ST_CONNECT];
    bit8  = 8'd1 << item.port;
    port_ok = (item.port != 3'd0) && (item.port <= n);
    rp_ok   = (ctrl.rst_port != 3'd0) && (32'(ctrl.rst_port) <= MAX_PORTS);
    for (int i = 0; i < MAX_PORTS; i++) begin
      phase_nxt[i] = phase[i];
      if (32'(item.port) == i + 1) ph = phase[i];
      if (32'(ctrl.rst_port) == i + 1) rph = phase[i];
    end
    ph_new = ph;

    if (item.action <= hpe_pkg::ACT_OTHER) c.in_flight = 1'b0;

    // action handling; requests gathered into one kind and port mask
    unique case (item.action)
      hpe_pkg::ACT_START_PWR: begin
        skind = hpe_pkg::K_POWER;
        smask = vmask(hpe_pkg::K_POWER, base_mask);
      end
      hpe_pkg::ACT_PWR_DONE: begin
        if (item.port == n && !c.pipe_open) begin
          c.pipe_open = 1'b1;
          r.open_status_pipe = 1'b1;
        end
      end
      hpe_pkg::ACT_STAT_DONE: begin
        if (port_ok) begin
          if (ph == hpe_pkg::PH_OFF || ph == hpe_pkg::PH_DISC) begin
            if (conn) begin
              ph_new = hpe_pkg::PH_DB1;
              r.start_debounce = (c.db_ports == 8'd0);
              c.db_ports = c.db_ports | bit8;
              skind = hpe_pkg::K_CLR_CONN;
              smask = bit8;
            end
          end else if (ph >= hpe_pkg::PH_DB1 && ph <= hpe_pkg::PH_DB5) begin
            if (conn) begin
              if (ph < hpe_pkg::PH_DB5) begin
                ph_new = ph + 4'd1;
              end else if (!(c.rst_busy || item.enum_busy)) begin
                c.rst_busy = 1'b1;
                c.db_ports = c.db_ports & ~bit8;
                ph_new     = hpe_pkg::PH_RESET;
                skind      = hpe_pkg::K_SETRESET;
                smask      = bit8;
                c.rst_port = item.port;
              end
            end else begin
              c.db_ports = c.db_ports & ~bit8;
              ph_new     = hpe_pkg::PH_DISC;
            end
          end else if (ph == hpe_pkg::PH_RESET) begin
            if (item.status[hpe_pkg::ST_ENABLE]) begin
              skind  = hpe_pkg::K_CLR_RESET;
              smask  = bit8;
              ph_new = hpe_pkg::PH_RECOV;
              c.rst_speed = item.status[hpe_pkg::ST_LOW]  ? 2'd1 :
                            item.status[hpe_pkg::ST_HIGH] ? 2'd2 : 2'd0;
              r.start_reset_timer = 1'b1;
            end else if (!conn) begin
              skind      = hpe_pkg::K_CLR_CONN;
              smask      = bit8;
              c.rst_busy = 1'b0;
              ph_new     = hpe_pkg::PH_DISC;
            end
          end else if (ph == hpe_pkg::PH_RECOV) begin
            if (!conn) begin
              skind      = hpe_pkg::K_CLR_CONN;
              smask      = bit8;
              c.rst_busy = 1'b0;
              ph_new     = hpe_pkg::PH_DISC;
            end
          end else if (ph == hpe_pkg::PH_ACTIVE) begin
            if (!conn) begin
              r.detach_device = 1'b1;
              r.event_port    = item.port;
              skind  = hpe_pkg::K_CLR_CONN;
              smask  = bit8;
              ph_new = hpe_pkg::PH_DISC;
            end
          end
          for (int i = 0; i < MAX_PORTS; i++) begin
            if (32'(item.port) == i + 1) phase_nxt[i] = ph_new;
          end
        end
      end
      hpe_pkg::ACT_CHANGE: begin
        skind = hpe_pkg::K_GETSTAT;
        smask = item.change_bits & base_mask;
      end
      hpe_pkg::ACT_DB_TICK: begin
        if (c.db_ports != 8'd0) begin
          skind = hpe_pkg::K_GETSTAT;
          smask = c.db_ports & base_mask & 8'hFE;
          r.start_debounce = 1'b1;
        end
      end
      hpe_pkg::ACT_RST_TICK: begin
        if (rp_ok && rph == hpe_pkg::PH_RECOV) begin
          c.rst_port      = 3'd0;
          r.attach_device = 1'b1;
          r.attach_speed  = c.rst_speed;
          r.event_port    = ctrl.rst_port;
          c.rst_busy      = 1'b0;
          for (int i = 0; i < MAX_PORTS; i++) begin
            if (32'(ctrl.rst_port) == i + 1) phase_nxt[i] = hpe_pkg::PH_ACTIVE;
          end
        end
      end
      default: ;
    endcase

    // issue the lowest port of the mask, or park it as pending
    smask = vmask(skind, smask & base_mask);
    if (smask != 8'd0) begin
      if (!c.in_flight) begin
        lb = lowbit(smask);
        c.in_flight = 1'b1;
        c.pending[skind] = (c.pending[skind] | smask) & ~lb;
        r.req_valid = 1'b1;
        r.req_kind  = skind;
        r.req_port  = enc(lb);
      end else begin
        c.pending[skind] = c.pending[skind] | smask;
      end
    end

    // after a completion, pick the best pending request, scrubbing stale bits
    if (item.action <= hpe_pkg::ACT_OTHER && !c.in_flight) begin
      for (int k = 0; k < 8; k++) begin
        if (!found) begin
          c.pending[k] = c.pending[k] & vmask(3'(k), base_mask);
          if (c.pending[k] != 8'd0) begin
            found = 1'b1;
            lb = lowbit(c.pending[k]);
            c.pending[k] = c.pending[k] & ~lb;
            c.in_flight = 1'b1;
            r.req_valid = 1'b1;
            r.req_kind  = 3'(k);
            r.req_port  = enc(lb);
          end
        end
      end
    end

    ctrl_nxt = c;
    res      = r;
  end

endmodule
